### rtl/sae_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sae_pkg
// Types and codes for the stack arithmetic engine.
// ----------------------------------------------------------------------------
package sae_pkg;

    // command kinds
    typedef enum logic [2:0] {
        K_PUSH   = 3'd0,
        K_POP    = 3'd1,
        K_PEEK_T = 3'd2,
        K_PEEK_B = 3'd3,
        K_ADD    = 3'd4,
        K_SUB    = 3'd5,
        K_MUL    = 3'd6,
        K_DIV    = 3'd7
    } t_kind;

    // result status codes
    typedef enum logic [2:0] {
        S_OK    = 3'd0,
        S_FULL  = 3'd1,
        S_EMPTY = 3'd2,
        S_RANGE = 3'd3,
        S_FEW   = 3'd4,
        S_DIVZ  = 3'd5
    } t_status;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_TOP,
        ST_SECOND,
        ST_EXEC,
        ST_DIV,
        ST_FIX,
        ST_WRITE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] push_value;
        logic [9:0]         peek_index;
    } t_in;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [2:0]         status;
        logic [10:0]        depth_after;
    } t_out;

endpackage

### rtl/stack_arithmetic_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_arithmetic_engine_top
// Bounded stack of signed words with push, pop, peek and arithmetic.
//
//   channel | valid        | stall        | payload
//   --------+--------------+--------------+---------------------
//   command | i_in_valid   | o_in_stall   | i_in_data  (t_in)
//   result  | o_out_valid  | i_out_stall  | o_out_data (t_out)
//
// push and the full, empty, range and too-few errors end after decode; pop
// and peek add a registered word-memory read; add/sub/mul read two words,
// execute and write back; divide by zero ends at execute; divide adds the radix-2 divider loop.
// one command is in flight at a time; a new one enters once its result is
// in the output register, which holds while i_out_stall is high.
// reset clears the word count, the state and the output valid; the memory needs no clearing.
// ----------------------------------------------------------------------------
module stack_arithmetic_engine_top #(
    parameter int STACK_DEPTH = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  sae_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output sae_pkg::t_out o_out_data
);
    import sae_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int XW = DW + 11;
    localparam logic [DW-1:0] FULL_CNT = DW'(STACK_DEPTH);

    t_state             r_state, n_state;
    t_kind              r_kind;
    logic [31:0]        r_pval;
    logic [9:0]         r_idx;
    logic [DW-1:0]      r_depth, n_depth;
    logic [31:0]        r_top, n_top;
    logic [31:0]        r_sec, n_sec;
    logic [31:0]        r_res, n_res;
    t_status            r_status, n_status;
    logic [31:0]        r_quo, n_quo;
    logic [31:0]        r_rem, n_rem;
    logic [31:0]        r_dmag, n_dmag;
    logic               r_neg, n_neg;
    logic [4:0]         r_cnt, n_cnt;
    t_out               r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [31:0]        mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [31:0]        mem_rdata;

    logic               in_xfer;
    logic               out_free;
    logic [AW-1:0]      addr_m1;
    logic [AW-1:0]      addr_m2;
    logic [XW-1:0]      depth_x;
    logic [XW-1:0]      idx_x;
    logic [63:0]        prod;
    logic [32:0]        div_shift;
    logic               div_ge;

    sae_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // handshake
    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_xfer     = i_in_valid && (r_state == ST_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // address arithmetic
    assign addr_m1   = AW'(r_depth - DW'(1));
    assign addr_m2   = AW'(r_depth - DW'(2));
    assign depth_x   = XW'(r_depth);
    assign idx_x     = XW'(r_idx);
    assign prod      = r_sec * r_top;
    assign div_shift = {r_rem, r_quo[31]};
    assign div_ge    = (div_shift >= {1'b0, r_dmag});

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (r_kind)
                    K_PUSH: n_state = ST_DONE;
                    K_POP: n_state = (r_depth == '0) ? ST_DONE : ST_TOP;
                    K_PEEK_T, K_PEEK_B: n_state = (idx_x >= depth_x) ? ST_DONE : ST_TOP;
                    default: n_state = (r_depth < DW'(2)) ? ST_DONE : ST_TOP;
                endcase
            end
            ST_TOP: begin
                if (r_kind == K_POP || r_kind == K_PEEK_T || r_kind == K_PEEK_B) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_SECOND;
                end
            end
            ST_SECOND: n_state = ST_EXEC;
            ST_EXEC: begin
                if (r_kind != K_DIV) begin
                    n_state = ST_WRITE;
                end else if (r_top == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_cnt == 5'd31) begin
                    n_state = ST_FIX;
                end
            end
            ST_FIX: n_state = ST_WRITE;
            ST_WRITE: n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_depth     = r_depth;
        n_top       = r_top;
        n_sec       = r_sec;
        n_res       = r_res;
        n_status    = r_status;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_dmag      = r_dmag;
        n_neg       = r_neg;
        n_cnt       = r_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        mem_we      = 1'b0;
        mem_waddr   = r_depth[AW-1:0];
        mem_wdata   = r_pval;
        mem_raddr   = addr_m1;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_DECODE: begin
                n_res    = '0;
                n_status = S_OK;
                case (r_kind)
                    K_PUSH: begin
                        if (r_depth >= FULL_CNT) begin
                            n_status = S_FULL;
                        end else begin
                            mem_we  = 1'b1;
                            n_depth = r_depth + DW'(1);
                        end
                    end
                    K_POP: begin
                        if (r_depth == '0) begin
                            n_status = S_EMPTY;
                        end
                    end
                    K_PEEK_T: begin
                        mem_raddr = AW'(depth_x - XW'(1) - idx_x);
                        if (idx_x >= depth_x) begin
                            n_status = S_RANGE;
                        end
                    end
                    K_PEEK_B: begin
                        mem_raddr = AW'(idx_x);
                        if (idx_x >= depth_x) begin
                            n_status = S_RANGE;
                        end
                    end
                    default: begin
                        if (r_depth < DW'(2)) begin
                            n_status = S_FEW;
                        end
                    end
                endcase
            end
            ST_TOP: begin
                mem_raddr = addr_m2;
                n_top     = mem_rdata;
                if (r_kind == K_POP) begin
                    n_res   = mem_rdata;
                    n_depth = r_depth - DW'(1);
                end else if (r_kind == K_PEEK_T || r_kind == K_PEEK_B) begin
                    n_res = mem_rdata;
                end
            end
            ST_SECOND: begin
                n_sec = mem_rdata;
            end
            ST_EXEC: begin
                case (r_kind)
                    K_ADD: n_res = r_sec + r_top;
                    K_SUB: n_res = r_sec - r_top;
                    K_MUL: n_res = prod[31:0];
                    default: begin
                        n_quo  = r_sec[31] ? (32'd0 - r_sec) : r_sec;
                        n_dmag = r_top[31] ? (32'd0 - r_top) : r_top;
                        n_neg  = r_sec[31] ^ r_top[31];
                        n_rem  = '0;
                        n_cnt  = '0;
                        if (r_top == '0) begin
                            n_status = S_DIVZ;
                            n_depth  = r_depth - DW'(2);
                        end
                    end
                endcase
            end
            ST_DIV: begin
                // one restoring step per cycle
                n_rem = div_ge ? 32'(div_shift - {1'b0, r_dmag}) : div_shift[31:0];
                n_quo = {r_quo[30:0], div_ge};
                n_cnt = r_cnt + 5'd1;
            end
            ST_FIX: begin
                // floor correction when signs differ
                if (r_neg) begin
                    n_res = 32'd0 - r_quo - {31'd0, (r_rem != '0)};
                end else begin
                    n_res = r_quo;
                end
            end
            ST_WRITE: begin
                mem_we    = 1'b1;
                mem_waddr = addr_m2;
                mem_wdata = r_res;
                n_depth   = r_depth - DW'(1);
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out.result_value = r_res;
                    n_out.status       = r_status;
                    n_out.depth_after  = 11'(r_depth);
                    n_out_valid        = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // command capture
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_kind <= t_kind'(i_in_data.kind);
            r_pval <= i_in_data.push_value;
            r_idx  <= i_in_data.peek_index;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_top    <= n_top;
        r_sec    <= n_sec;
        r_res    <= n_res;
        r_status <= n_status;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_dmag   <= n_dmag;
        r_neg    <= n_neg;
        r_cnt    <= n_cnt;
        r_out    <= n_out;
    end
endmodule

### rtl/sae_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sae_ram
// Generic single-write, single-read memory with a registered read.
// ----------------------------------------------------------------------------
module sae_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
